/* sv/tmfd_pkg.sv */
// Package for the TM transfer frame decoder.
// Holds region and outcome codes, length limits and the header and word types.
// No dependencies.
package tmfd_pkg;

    // Length limits of a frame in octets.
    localparam int MAX_DATA_BYTES  = 1024;
    localparam int FRAME_LEN_MIN   = 8;
    localparam int FRAME_LEN_MAX   = 2048;
    localparam int FRAME_LEN_RESET = 1115;
    localparam int SEC_MIN_FRAME   = 10;
    localparam int PRI_HDR_LEN     = 6;
    localparam int OCF_LEN         = 4;
    localparam int FECF_LEN        = 2;

    // Region tag for each octet.
    typedef enum logic [2:0] {
        REG_PRI_HDR  = 3'd0,
        REG_SEC_ID   = 3'd1,
        REG_SEC_DATA = 3'd2,
        REG_DATA     = 3'd3,
        REG_OCF      = 3'd4,
        REG_FECF     = 3'd5,
        REG_DISCARD  = 3'd6
    } region_t;

    // Frame outcome.
    typedef enum logic [1:0] {
        OUT_OK        = 2'd0,
        OUT_INV_PARAM = 2'd1,
        OUT_INV_FRAME = 2'd2
    } outcome_t;

    // Header fields latched from the primary and secondary headers.
    typedef struct packed {
        logic [1:0]  shver;
        logic [15:0] dfs;
        logic [7:0]  vc;
        logic [7:0]  mc;
        logic        ocf;
        logic [2:0]  vcid;
        logic [9:0]  scid;
        logic [1:0]  ver;
    } tmfd_hdr_t;

    // One decoded result word.
    typedef struct packed {
        logic       last;
        outcome_t   outcome;
        tmfd_hdr_t  hdr;
        region_t    region;
        logic [7:0] data;
    } tmfd_res_t;

endpackage

/* sv/tmfd_parser.sv */
// Frame position counter and header parser of the TM transfer frame decoder.
// Depends on tmfd_pkg; produces the decoded word for the octet on its input.
module tmfd_parser
    import tmfd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        accept,
    input  logic [7:0]  in_byte,
    input  logic [11:0] frame_length,
    output tmfd_res_t   res
);

    logic [10:0] pos_reg, pos_next;
    tmfd_hdr_t   hdr_reg, hdr_cur, hdr_next;
    logic [5:0]  shlen_reg, shlen_cur, shlen_next;
    outcome_t    err_reg, err_cur, err_next;
    logic [11:0] len;
    logic [2:0]  ocf_len;
    logic        first;
    logic        last;
    region_t     region;

    // Checks that the frame holds the overhead and that the data field fits.
    function automatic outcome_t len_check(logic [11:0] l, logic [6:0] over);
        logic [12:0] lw;
        logic [12:0] ow;
        lw = {1'b0, l};
        ow = {6'd0, over};
        if (lw < ow) begin
            return OUT_INV_FRAME;
        end
        if (lw > ow + 13'(MAX_DATA_BYTES)) begin
            return OUT_INV_FRAME;
        end
        return OUT_OK;
    endfunction

    // Effective framing length: a zero length counts one octet, too long counts the maximum.
    always_comb begin
        if (frame_length == 12'd0) begin
            len = 12'd1;
        end else if (frame_length > 12'(FRAME_LEN_MAX)) begin
            len = 12'(FRAME_LEN_MAX);
        end else begin
            len = frame_length;
        end
    end

    // State as seen by this octet: everything is cleared at the start of a frame.
    assign first = (pos_reg == 11'd0);

    always_comb begin
        if (first) begin
            hdr_cur   = '0;
            shlen_cur = 6'd0;
            if (frame_length < 12'(FRAME_LEN_MIN) || frame_length > 12'(FRAME_LEN_MAX)) begin
                err_cur = OUT_INV_PARAM;
            end else begin
                err_cur = OUT_OK;
            end
        end else begin
            hdr_cur   = hdr_reg;
            shlen_cur = shlen_reg;
            err_cur   = err_reg;
        end
    end

    assign ocf_len = hdr_cur.ocf ? 3'(OCF_LEN) : 3'd0;

    // Field latching, length checks and region tagging.
    always_comb begin
        hdr_next   = hdr_cur;
        shlen_next = shlen_cur;
        err_next   = err_cur;
        region     = REG_DISCARD;
        if (err_cur == OUT_OK) begin
            if (pos_reg < 11'(PRI_HDR_LEN)) begin
                region = REG_PRI_HDR;
                case (pos_reg[2:0])
                    3'd0: begin
                        hdr_next.ver  = in_byte[7:6];
                        hdr_next.scid = {in_byte[5:0], 4'd0};
                    end
                    3'd1: begin
                        hdr_next.scid = hdr_cur.scid | {6'd0, in_byte[7:4]};
                        hdr_next.vcid = in_byte[3:1];
                        hdr_next.ocf  = in_byte[0];
                    end
                    3'd2: hdr_next.mc = in_byte;
                    3'd3: hdr_next.vc = in_byte;
                    3'd4: hdr_next.dfs = {in_byte, 8'd0};
                    default: begin
                        hdr_next.dfs = hdr_cur.dfs | {8'd0, in_byte};
                        if (!hdr_cur.dfs[15]) begin
                            err_next = len_check(len, 7'd8 + {4'd0, ocf_len});
                        end
                    end
                endcase
            end else if (hdr_cur.dfs[15] && pos_reg == 11'(PRI_HDR_LEN)) begin
                region = REG_SEC_ID;
                if (len < 12'(SEC_MIN_FRAME)) begin
                    err_next = OUT_INV_FRAME;
                end else begin
                    hdr_next.shver = in_byte[7:6];
                    shlen_next     = in_byte[5:0];
                    if (in_byte[5:0] == 6'd0) begin
                        err_next = OUT_INV_FRAME;
                    end else begin
                        err_next = len_check(len, 7'd9 + {1'b0, in_byte[5:0]}
                                                 + {4'd0, ocf_len});
                    end
                end
            end else if (hdr_cur.dfs[15] && pos_reg < 11'd7 + {5'd0, shlen_cur}) begin
                region = REG_SEC_DATA;
            end else if ({2'd0, pos_reg} + 13'(FECF_LEN) + {10'd0, ocf_len}
                         < {1'b0, len}) begin
                region = REG_DATA;
            end else if ({2'd0, pos_reg} + 13'(FECF_LEN) < {1'b0, len}) begin
                region = REG_OCF;
            end else begin
                region = REG_FECF;
            end
        end
    end

    // Frame end and next position.
    assign last     = ({1'b0, pos_reg} + 12'd1 >= len);
    assign pos_next = last ? 11'd0 : pos_reg + 11'd1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= 11'd0;
            err_reg   <= OUT_OK;
            hdr_reg   <= '0;
            shlen_reg <= 6'd0;
        end else if (accept) begin
            pos_reg   <= pos_next;
            err_reg   <= err_next;
            hdr_reg   <= hdr_next;
            shlen_reg <= shlen_next;
        end
    end

    // Decoded word for the octet being accepted.
    always_comb begin
        res.data    = in_byte;
        res.region  = region;
        res.hdr     = hdr_next;
        res.outcome = err_next;
        res.last    = last;
    end

endmodule

/* sv/tm_transfer_frame_decoder_unit.sv */
// Top level of the TM transfer frame decoder: stream ports, length register, output register.
// Depends on tmfd_pkg and tmfd_parser.
// The result word of an accepted input word is registered and appears on the master side in the next cycle.
// Throughput: one word per cycle while m_tready is high; the parser and the single output register set this.
// Input is taken whenever the output register is empty or being drained in the same cycle.
// Reset (aresetn low, synchronous) empties the output, sets the frame length to 1115
// and restarts framing at the first octet of a frame.
module tm_transfer_frame_decoder_unit
    import tmfd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [11:0] cfg_wr_data,   // frame_length
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,       // in_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    // out_byte[7:0], frame_version[9:8], spacecraft[19:10], virtual_channel[22:20],
    // ocf_flag[23], master_count[31:24], virtual_count[39:32], status_word[55:40],
    // sec_header_version[57:56], outcome[59:58], zero[63:60]
    output logic [63:0] m_tdata,
    output logic [2:0]  m_tuser,       // region
    output logic        m_tlast        // frame_end
);

    logic [11:0] frame_length_reg;
    logic        valid_reg, valid_next;
    tmfd_res_t   res_reg;
    tmfd_res_t   res;
    logic        accept;

    // Frame length register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_length_reg <= 12'(FRAME_LEN_RESET);
        end else if (cfg_wr_en) begin
            frame_length_reg <= cfg_wr_data;
        end
    end

    // Handshake: a new word enters when the output register is empty or frees up this cycle.
    assign s_tready = !valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    tmfd_parser u_parser (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (accept),
        .in_byte      (s_tdata),
        .frame_length (frame_length_reg),
        .res          (res)
    );

    // Output register.
    always_comb begin
        if (accept) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            res_reg <= res;
        end
    end

    // Pack the result word onto the master side.
    assign m_tvalid = valid_reg;
    assign m_tdata  = {4'd0, res_reg.outcome, res_reg.hdr.shver, res_reg.hdr.dfs,
                       res_reg.hdr.vc, res_reg.hdr.mc, res_reg.hdr.ocf, res_reg.hdr.vcid,
                       res_reg.hdr.scid, res_reg.hdr.ver, res_reg.data};
    assign m_tuser  = res_reg.region;
    assign m_tlast  = res_reg.last;

    // An invalid length parameter discards every octet of the frame.
    a_param_discard: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[59:58] == OUT_INV_PARAM) |-> (m_tuser == REG_DISCARD))
        else $error("invalid parameter word not tagged discard");

    // A secondary id octet only appears when the status word flags a secondary header.
    a_sec_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == REG_SEC_ID) |-> m_tdata[55])
        else $error("secondary id without secondary header flag");

    // With the output register empty the slave side must be ready.
    a_ready_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled while output register empty");

    // An accepted word is on the master side in the next cycle.
    a_accept_shown: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> m_tvalid)
        else $error("accepted word not presented");

endmodule
